/* sv/dtfc_pkg.sv */
// Package for the decimal integer type fit classifier.
// Holds the bound digit tables, relation codes and shared helpers.
// No dependencies.
package dtfc_pkg;

    // Number of type bounds tracked: positive signed, negative signed, unsigned
    localparam int unsigned NUM_BOUNDS = 12;
    // Longest bound has 20 digits; the count saturates one past it
    localparam int unsigned MAX_BOUND_DIGITS = 20;
    localparam logic [4:0]  DIGIT_SAT = 5'd21;

    // Character codes
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Fits mask layout
    localparam int unsigned NUM_TYPES = 4;

    // How the digits so far compare with a bound's digits
    typedef enum logic [1:0] {
        REL_EQ = 2'd0,
        REL_LT = 2'd1,
        REL_GT = 2'd2
    } rel_t;

    // Bound digits as BCD, most significant digit at the top, zero padded
    localparam logic [79:0] BOUND_BCD [NUM_BOUNDS] = '{
        80'h1270_0000_0000_0000_0000,
        80'h3276_7000_0000_0000_0000,
        80'h2147_4836_4700_0000_0000,
        80'h9223_3720_3685_4775_8070,
        80'h1280_0000_0000_0000_0000,
        80'h3276_8000_0000_0000_0000,
        80'h2147_4836_4800_0000_0000,
        80'h9223_3720_3685_4775_8080,
        80'h2550_0000_0000_0000_0000,
        80'h6553_5000_0000_0000_0000,
        80'h4294_9672_9500_0000_0000,
        80'h1844_6744_0737_0955_1615
    };

    localparam logic [4:0] BOUND_LEN [NUM_BOUNDS] = '{
        5'd3, 5'd5, 5'd10, 5'd19,
        5'd3, 5'd5, 5'd10, 5'd19,
        5'd3, 5'd5, 5'd10, 5'd20
    };

    // Digit of bound idx at position pos (from the left); positions past
    // the end clamp to the last slot, and the value read there is never used
    function automatic logic [3:0] bound_digit(input logic [3:0] idx, input logic [4:0] pos);
        logic [4:0] pos_c;
        logic [4:0] sel;
        begin
            pos_c = (pos >= 5'(MAX_BOUND_DIGITS)) ? 5'(MAX_BOUND_DIGITS - 1) : pos;
            sel   = 5'(MAX_BOUND_DIGITS - 1) - pos_c;
            return BOUND_BCD[idx][{sel, 2'b00} +: 4];
        end
    endfunction

endpackage

/* sv/decimal_integer_type_fit_classifier.sv */
// Top level of the decimal integer type fit classifier.
// Depends on dtfc_pkg and dtfc_bound_track.
//
// Takes one character beat per cycle, with last marking the end of a token,
// and returns one result beat per token: which of s8..s64 and u8..u64 can
// hold the value, the sign and the saturating digit count. Throughput is one
// character per cycle. The result beat is registered: the last character
// lands in the input register, and once the result register is free the
// per-bound digit compare moves into it.
// Only a token end waiting behind a stalled result holds off char beats.
module decimal_integer_type_fit_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] fits_mask,
    output logic       negative,
    output logic [4:0] digit_count
);
    import dtfc_pkg::*;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Token state
    logic       sign_seen_reg, sign_seen_next;
    logic       token_bad_reg, token_bad_next;
    logic [4:0] digits_seen_reg, digits_seen_next;

    // Result stage
    logic       out_valid_reg;
    logic [7:0] fits_mask_reg, fits_mask_next;
    logic       negative_reg;
    logic [4:0] digit_count_reg;

    logic                  out_free;
    logic                  proc;
    logic                  is_minus;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [NUM_BOUNDS-1:0] bound_ok;

    // Handshake: a non-last beat always drains; a token end waits for a free result slot
    assign out_free   = !out_valid_reg || !result_stall;
    assign proc       = in_valid_reg && (!in_last_reg || out_free);
    assign char_stall = in_valid_reg && !proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!char_stall)
            in_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            in_char_reg <= char_code;
            in_last_reg <= last;
        end
    end

    // Character decode and token state update
    assign is_minus = (in_char_reg == CHAR_MINUS);
    assign is_digit = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign digit    = 4'(in_char_reg - CHAR_ZERO);

    always_comb
    begin
        sign_seen_next   = sign_seen_reg;
        token_bad_next   = token_bad_reg;
        digits_seen_next = digits_seen_reg;
        if (is_minus)
        begin
            // minus counts as a sign only as the very first character
            if (!sign_seen_reg && (digits_seen_reg == 5'd0) && !token_bad_reg)
                sign_seen_next = 1'b1;
            else
                token_bad_next = 1'b1;
        end
        else if (is_digit)
        begin
            if (digits_seen_reg < DIGIT_SAT)
                digits_seen_next = digits_seen_reg + 5'd1;
        end
        else
        begin
            token_bad_next = 1'b1;
        end
    end

    dtfc_bound_track u_bound_track (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (proc),
        .clear            (proc && in_last_reg),
        .is_digit         (is_digit),
        .digit            (digit),
        .digits_seen      (digits_seen_reg),
        .digits_seen_next (digits_seen_next),
        .bound_ok         (bound_ok)
    );

    // Fits mask: signed bits pick positive or negative bounds
    always_comb
    begin
        fits_mask_next = 8'd0;
        if (!token_bad_next && (digits_seen_next != 5'd0))
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                fits_mask_next[t] = sign_seen_next ? bound_ok[t + NUM_TYPES]
                                                   : bound_ok[t];
                fits_mask_next[t + NUM_TYPES] = !sign_seen_next && bound_ok[t + 2 * NUM_TYPES];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_seen_reg   <= 1'b0;
            token_bad_reg   <= 1'b0;
            digits_seen_reg <= 5'd0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                sign_seen_reg   <= 1'b0;
                token_bad_reg   <= 1'b0;
                digits_seen_reg <= 5'd0;
            end
            else
            begin
                sign_seen_reg   <= sign_seen_next;
                token_bad_reg   <= token_bad_next;
                digits_seen_reg <= digits_seen_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= proc && in_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            fits_mask_reg   <= fits_mask_next;
            negative_reg    <= sign_seen_next;
            digit_count_reg <= digits_seen_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign fits_mask    = fits_mask_reg;
    assign negative     = negative_reg;
    assign digit_count  = digit_count_reg;

endmodule

/* sv/dtfc_bound_track.sv */
// Per-bound digit compare state for the type fit classifier.
// Keeps one relation entry per type bound and flags which bounds hold.
// Depends on dtfc_pkg.
module dtfc_bound_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        clear,
    input  logic                        is_digit,
    input  logic [3:0]                  digit,
    input  logic [4:0]                  digits_seen,
    input  logic [4:0]                  digits_seen_next,
    output logic [dtfc_pkg::NUM_BOUNDS-1:0] bound_ok
);
    import dtfc_pkg::*;

    rel_t rel_reg  [NUM_BOUNDS];
    rel_t rel_next [NUM_BOUNDS];

    for (genvar b = 0; b < NUM_BOUNDS; b++) begin : g_bound
        logic [3:0] bd;

        // Compare the new digit at the first position not yet decided
        always_comb
        begin
            bd          = bound_digit(4'(b), digits_seen);
            rel_next[b] = rel_reg[b];
            if (is_digit && (digits_seen < BOUND_LEN[b]) && (rel_reg[b] == REL_EQ))
            begin
                if (digit < bd)
                    rel_next[b] = REL_LT;
                else if (digit > bd)
                    rel_next[b] = REL_GT;
            end
        end

        // Fits: shorter than the bound, or same length and not greater
        assign bound_ok[b] = (digits_seen_next < BOUND_LEN[b]) ||
                             ((digits_seen_next == BOUND_LEN[b]) && (rel_next[b] != REL_GT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rel_reg[b] <= REL_EQ;
            else if (clear)
                rel_reg[b] <= REL_EQ;
            else if (step)
                rel_reg[b] <= rel_next[b];
        end
    end

endmodule

/* sv/dtfc_checker.sv */
// Port-level checks for the decimal integer type fit classifier.
// Bound to the top level; sees only its ports.
module dtfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] fits_mask,
    input logic       negative,
    input logic [4:0] digit_count
);

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(fits_mask) &&
        $stable(negative) && $stable(digit_count))
        else $error("stalled result beat changed");

    // Negative values never fit an unsigned type
    a_neg_unsigned: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && negative |-> fits_mask[7:4] == 4'd0)
        else $error("negative value flagged as unsigned fit");

    // No digits or too many digits: nothing fits
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (digit_count == 5'd0 || digit_count > 5'd20) |-> fits_mask == 8'd0)
        else $error("fit reported for empty or overlong token");

    // Bounds are nested: fitting a narrow type implies fitting every wider one of the same signedness
    a_nested: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!fits_mask[0] || fits_mask[1]) && (!fits_mask[1] || fits_mask[2]) &&
        (!fits_mask[2] || fits_mask[3]) && (!fits_mask[4] || fits_mask[5]) &&
        (!fits_mask[5] || fits_mask[6]) && (!fits_mask[6] || fits_mask[7]))
        else $error("fit mask not nested by width");

endmodule

bind decimal_integer_type_fit_classifier dtfc_checker u_dtfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .fits_mask    (fits_mask),
    .negative     (negative),
    .digit_count  (digit_count)
);
